FILE: hdl/scd_pkg.sv
package scd_pkg;

	localparam int RANGE_W     = 32;
	localparam int OFFSET_W    = 17;
	localparam int DEPTH_W     = 16;
	localparam int RESULT_W    = 18;
	localparam int CFG_INDEX_W = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_SQUARED = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_FLIP_OFFSET   = CFG_INDEX_W'(1);

	// one classified point on its way from the front to the square root
	typedef struct packed {
		logic [RANGE_W-1:0] diff;    // R^2 - |p|^2, or zero when out of range
		logic               invert;
		logic               last;
	} scd_item_t;

endpackage

FILE: hdl/scd_front.sv
module scd_front #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   pos_x,
	input  logic signed [COORD_WIDTH-1:0]   pos_y,
	input  logic signed [COORD_WIDTH-1:0]   pos_z,
	input  logic                            invert,
	input  logic                            last_point,
	input  logic [scd_pkg::RANGE_W-1:0]     range_squared,
	output logic                            push_valid,
	input  logic                            push_ready,
	output scd_pkg::scd_item_t              push_item
);
	import scd_pkg::*;

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > RANGE_W) ? SUM_W : RANGE_W;

	logic [COORD_WIDTH-1:0] abs_x, abs_y, abs_z;
	logic [SQ_W-1:0]        sq_x_s1, sq_y_s1, sq_z_s1;
	logic                   inv_s1, last_s1, v_s1;
	logic [SUM_W-1:0]       sum_s2;
	logic                   inv_s2, last_s2, v_s2;
	logic                   adv;
	logic [CMP_W-1:0]       range_ext, sum_ext;
	logic                   in_range;

	// magnitude of the most negative code still fits as unsigned
	assign abs_x = pos_x[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_x) : COORD_WIDTH'(pos_x);
	assign abs_y = pos_y[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_y) : COORD_WIDTH'(pos_y);
	assign abs_z = pos_z[COORD_WIDTH-1] ? COORD_WIDTH'(-pos_z) : COORD_WIDTH'(pos_z);

	// hold the whole front while its last stage waits on a full queue
	assign adv      = !v_s2 || push_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s1 <= SQ_W'(abs_x) * SQ_W'(abs_x);
			sq_y_s1 <= SQ_W'(abs_y) * SQ_W'(abs_y);
			sq_z_s1 <= SQ_W'(abs_z) * SQ_W'(abs_z);
			inv_s1  <= invert;
			last_s1 <= last_point;
			sum_s2  <= SUM_W'(sq_x_s1) + SUM_W'(sq_y_s1) + SUM_W'(sq_z_s1);
			inv_s2  <= inv_s1;
			last_s2 <= last_s1;
		end
	end

	assign range_ext = CMP_W'(range_squared);
	assign sum_ext   = CMP_W'(sum_s2);
	assign in_range  = range_ext > sum_ext;

	assign push_valid       = v_s2;
	assign push_item.diff   = in_range ? RANGE_W'(range_ext - sum_ext) : '0;
	assign push_item.invert = inv_s2;
	assign push_item.last   = last_s2;

endmodule

FILE: hdl/scd_queue.sv
module scd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  scd_pkg::scd_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output scd_pkg::scd_item_t pop_item
);
	import scd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	scd_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: hdl/scd_back.sv
module scd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  scd_pkg::scd_item_t                  pop_item,
	input  logic signed [scd_pkg::OFFSET_W-1:0] flip_offset,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [scd_pkg::RESULT_W-1:0] depth_out,
	output logic                                last_out
);
	import scd_pkg::*;

	localparam int TRIAL_W = RANGE_W + 2;

	// one result bit per stage, most significant first
	logic [RANGE_W-1:0] rem_s  [DEPTH_W-1];
	logic [DEPTH_W-1:0] root_s [DEPTH_W];
	logic               v_s    [DEPTH_W];
	logic               inv_s  [DEPTH_W];
	logic               last_s [DEPTH_W];
	logic               adv;

	logic [DEPTH_W-1:0]         depth;
	logic signed [RESULT_W-1:0] result;
	logic                       out_valid_q;
	logic signed [RESULT_W-1:0] depth_q;
	logic                       last_q;

	// advance the whole chain whenever the output register can take a value
	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;

	for (genvar j = 0; j < DEPTH_W; j++) begin : g_stage
		localparam int K = DEPTH_W - 1 - j;
		logic [RANGE_W-1:0] rem_in;
		logic [DEPTH_W-1:0] root_in;
		logic               v_in, inv_in, last_in;
		logic [TRIAL_W-1:0] trial;
		logic               take;

		if (j == 0) begin : g_head
			assign rem_in  = pop_item.diff;
			assign root_in = '0;
			assign v_in    = pop_valid;
			assign inv_in  = pop_item.invert;
			assign last_in = pop_item.last;
		end else begin : g_body
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign v_in    = v_s[j-1];
			assign inv_in  = inv_s[j-1];
			assign last_in = last_s[j-1];
		end

		// (root + 2^K)^2 - root^2 against what is left of the radicand
		assign trial = (TRIAL_W'(root_in) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
		assign take  = TRIAL_W'(rem_in) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[j] <= take ? (root_in | (DEPTH_W'(1) << K)) : root_in;
				inv_s[j]  <= inv_in;
				last_s[j] <= last_in;
			end
		end

		// the last stage has no use for what is left over
		if (j < DEPTH_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[j] <= take ? RANGE_W'(TRIAL_W'(rem_in) - trial) : rem_in;
				end
			end
		end
	end

	assign depth  = root_s[DEPTH_W-1];
	assign result = inv_s[DEPTH_W-1]
		? RESULT_W'(flip_offset) - $signed(RESULT_W'(depth))
		: $signed(RESULT_W'(depth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s[DEPTH_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			depth_q <= result;
			last_q  <= last_s[DEPTH_W-1];
		end
	end

	assign out_valid = out_valid_q;
	assign depth_out = depth_q;
	assign last_out  = last_q;

endmodule

FILE: hdl/sphere_cap_depth.sv
// Channel  Direction  Carries
// -------  ---------  --------------------------------------------------------
// s_axis   in         one point: x, y, z (signed Q8.8), invert, last marker
// m_axis   out        one result: depth or flipped depth (signed Q10.8), last
// cfg      in         register write: 0 = range_squared, 1 = flip_offset
//
// One point is taken every cycle while s_axis_tready is high and gives
// exactly one result. A point passes the front (squares, then sum; the range
// compare sits on the way into the queue), the queue, the square root (one
// result bit per stage) and the output register. Reset clears the valid bits
// and both registers to zero and empties the queue. A stall on m_axis holds
// the square root chain; the 4-entry queue soaks up the front, which stops
// taking points once it is full.
module sphere_cap_depth #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // pos_x, pos_y, pos_z
	input  logic                                 s_axis_tuser,  // invert
	input  logic                                 s_axis_tlast,  // last_point
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((scd_pkg::RESULT_W+7)/8)*8-1:0] m_axis_tdata,  // depth_out
	output logic                                 m_axis_tlast,  // last_out
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [scd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [scd_pkg::RANGE_W-1:0]          cfg_data
);
	import scd_pkg::*;

	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	logic [RANGE_W-1:0]         range_squared_q;
	logic signed [OFFSET_W-1:0] flip_offset_q;
	logic signed [COORD_WIDTH-1:0] pos_x, pos_y, pos_z;

	logic                       push_valid, push_ready;
	scd_item_t                  push_item;
	logic                       pop_valid, pop_ready;
	scd_item_t                  pop_item;
	logic signed [RESULT_W-1:0] depth_out;

	// writes land at once; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_squared_q <= '0;
			flip_offset_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RANGE_SQUARED: range_squared_q <= cfg_data;
				CFG_FLIP_OFFSET:   flip_offset_q   <= cfg_data[OFFSET_W-1:0];
				default:           ;
			endcase
		end
	end

	// unpack the coordinates, x in the lowest bits
	assign pos_x = s_axis_tdata[COORD_WIDTH-1:0];
	assign pos_y = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign pos_z = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

	// front: square, sum and classify against the range
	scd_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.invert        (s_axis_tuser),
		.last_point    (s_axis_tlast),
		.range_squared (range_squared_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	// short queue so front and back stall independently
	scd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back: pipelined square root, optional flip, output register
	scd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.flip_offset (flip_offset_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.depth_out   (depth_out),
		.last_out    (m_axis_tlast)
	);

	// pad the result with zeros up to a whole byte
	assign m_axis_tdata = OUT_TDATA_W'($unsigned(depth_out));

endmodule
